>>> hdl/jti_pkg.sv
// ----------------------------------------------------------------------------
// jti_pkg
// Shared types and constants of the joint trajectory interpolator.
// ----------------------------------------------------------------------------
package jti_pkg;

  localparam int ANGLE_W = 16;
  localparam int DUR_W   = 12;
  localparam int MODE_W  = 2;
  localparam int FRAC_W  = 16;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [DUR_W-1:0]          dur_t;
  typedef logic [MODE_W-1:0]         mode_t;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_BAD_MODE,
    STATUS_ZERO_DUR,
    STATUS_BUSY
  } status_t;

  localparam logic  FUNC_START  = 1'b0;
  localparam mode_t MODE_LINEAR = 2'd1;
  localparam mode_t MODE_CUBIC  = 2'd2;

  localparam angle_t HOME_SHOULDER = -16'sd4096;
  localparam angle_t HOME_ELBOW    = 16'sd4096;

  localparam logic [FRAC_W:0]   ONE_Q16  = 17'd65536;
  localparam logic [FRAC_W-1:0] HALF_Q16 = 16'd32768;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TDIV_GO,
    S_TDIV_WAIT,
    S_T2_MUL,
    S_T2_RND,
    S_T3_MUL,
    S_S_CALC,
    S_J_MUL,
    S_J_DIV_GO,
    S_J_DIV_WAIT,
    S_J_FIN,
    S_OUT
  } state_t;

endpackage

>>> hdl/jti_if.sv
// ----------------------------------------------------------------------------
// jti_if
// Valid/ready channels of the interpolator: move/tick requests and samples.
// ----------------------------------------------------------------------------
interface jti_in_if;
  import jti_pkg::*;

  logic   valid;
  logic   ready;
  logic   func;
  mode_t  mode;
  dur_t   duration_ticks;
  angle_t target_rotation;
  angle_t target_shoulder;
  angle_t target_elbow;

  modport source (
    output valid, func, mode, duration_ticks,
    output target_rotation, target_shoulder, target_elbow,
    input  ready
  );

  modport sink (
    input  valid, func, mode, duration_ticks,
    input  target_rotation, target_shoulder, target_elbow,
    output ready
  );
endinterface

interface jti_out_if;
  import jti_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  logic    sample_valid;
  angle_t  angle_rotation;
  angle_t  angle_shoulder;
  angle_t  angle_elbow;
  logic    last_sample;

  modport source (
    output valid, status, sample_valid,
    output angle_rotation, angle_shoulder, angle_elbow, last_sample,
    input  ready
  );

  modport sink (
    input  valid, status, sample_valid,
    input  angle_rotation, angle_shoulder, angle_elbow, last_sample,
    output ready
  );
endinterface

>>> hdl/jti_div.sv
// ----------------------------------------------------------------------------
// jti_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jti_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   trial_w;
  logic             ge_w;

  assign trial_w = {rem_r, quo_r[NUM_W-1]};
  assign ge_w    = trial_w >= {1'b0, den};
  assign busy    = cnt_r != '0;
  assign quot    = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
    end else if (busy) begin
      rem_r <= ge_w ? DEN_W'(trial_w - {1'b0, den}) : DEN_W'(trial_w);
      quo_r <= {quo_r[NUM_W-2:0], ge_w};
    end
  end

endmodule

>>> hdl/joint_trajectory_interpolator_top.sv
// ----------------------------------------------------------------------------
// joint_trajectory_interpolator_top
// Linear and cubic joint-space interpolation over a move of N sample ticks.
// Start or idle tick: goes from S_IDLE straight to S_OUT, which loads the result.
// Linear tick: one product and one serial divide per joint.
// Cubic tick: one serial divide for t, then the
// shared 17x17 multiplier for t^2, t^3 and one product per joint.
// One item in flight; synchronous reset restores the home pose, idle, no move.
// ----------------------------------------------------------------------------
module joint_trajectory_interpolator_top #(
  parameter int JOINTS    = 3,
  parameter int STEP_BITS = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  jti_in_if.sink    in_chan,
  jti_out_if.source out_chan
);
  import jti_pkg::*;

  localparam int NUM_W = FRAC_W + STEP_BITS;
  localparam int JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic [JW-1:0] LAST_J = JW'(JOINTS - 1);

  state_t state_r, state_nxt;

  angle_t start_r [JOINTS];
  angle_t goal_r  [JOINTS];
  angle_t res_r   [JOINTS];

  logic [STEP_BITS-1:0] step_index_r;
  logic [STEP_BITS-1:0] step_total_r;
  logic [STEP_BITS-1:0] k_r;
  logic                 cubic_r;
  logic                 moving_r;
  logic [JW-1:0]        j_r;

  logic [FRAC_W:0]      t_r;
  logic [FRAC_W:0]      t2_r;
  logic [FRAC_W:0]      s_r;
  logic [2*FRAC_W+1:0]  p_r;

  status_t res_status_r;
  logic    res_sample_r;
  logic    res_last_r;

  logic    out_valid_r;
  status_t out_status_r;
  logic    out_sample_r;
  logic    out_last_r;
  angle_t  out_rot_r;
  angle_t  out_sho_r;
  angle_t  out_elb_r;

  logic                 in_ready_w;
  logic                 accept_w;
  logic                 div_start_w;
  logic                 div_busy_w;
  logic [NUM_W-1:0]     div_num_w;
  logic [NUM_W-1:0]     div_quot_w;
  logic                 out_load_w;
  logic                 fin_w;
  logic [STEP_BITS-1:0] dur_w;
  logic [STEP_BITS-1:0] k_w;
  logic [FRAC_W:0]      mul_a_w;
  logic [FRAC_W:0]      mul_b_w;
  logic [FRAC_W:0]      rnd_w;
  logic signed [19:0]   s_raw_w;
  logic [FRAC_W:0]      s_clamp_w;
  angle_t               start_sel_w;
  angle_t               goal_sel_w;
  logic signed [16:0]   d_w;
  logic [15:0]          mag_w;
  logic [FRAC_W:0]      r_w;
  logic signed [17:0]   sum_w;
  angle_t               sample_w;
  angle_t               rot_sel_w;
  angle_t               sho_sel_w;
  angle_t               elb_sel_w;

  assign accept_w      = in_chan.valid && in_ready_w;
  assign in_chan.ready = in_ready_w;

  assign dur_w = STEP_BITS'(in_chan.duration_ticks);
  assign k_w   = step_index_r + STEP_BITS'(1);

  assign start_sel_w = start_r[j_r];
  assign goal_sel_w  = goal_r[j_r];
  assign d_w         = 17'(goal_sel_w) - 17'(start_sel_w);
  assign mag_w       = d_w[16] ? 16'(-d_w) : 16'(d_w);

  assign rnd_w   = 17'((p_r + 34'(HALF_Q16)) >> FRAC_W);
  assign s_raw_w = $signed(20'(t2_r) + 20'({t2_r, 1'b0})) - $signed(20'({rnd_w, 1'b0}));

  always_comb begin
    if (s_raw_w < 20'sd0) begin
      s_clamp_w = '0;
    end else if (s_raw_w > $signed(20'(ONE_Q16))) begin
      s_clamp_w = ONE_Q16;
    end else begin
      s_clamp_w = 17'(s_raw_w);
    end
  end

  always_comb begin
    mul_a_w = '0;
    mul_b_w = '0;
    case (state_r)
      S_T2_MUL: begin
        mul_a_w = t_r;
        mul_b_w = t_r;
      end
      S_T3_MUL: begin
        mul_a_w = t2_r;
        mul_b_w = t_r;
      end
      S_J_MUL: begin
        mul_a_w = 17'(mag_w);
        mul_b_w = cubic_r ? s_r : 17'(k_r);
      end
      default: begin
        mul_a_w = '0;
        mul_b_w = '0;
      end
    endcase
  end

  always_comb begin
    if (state_r == S_TDIV_GO) begin
      div_num_w = {k_r, {FRAC_W{1'b0}}} + NUM_W'(step_total_r >> 1);
    end else begin
      div_num_w = NUM_W'(p_r) + NUM_W'(step_total_r >> 1);
    end
  end

  jti_div #(
    .NUM_W (NUM_W),
    .DEN_W (STEP_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_w),
    .num   (div_num_w),
    .den   (step_total_r),
    .busy  (div_busy_w),
    .quot  (div_quot_w)
  );

  assign fin_w = (state_r == S_J_FIN) || ((state_r == S_J_DIV_WAIT) && !div_busy_w);
  assign r_w   = (state_r == S_J_FIN) ? rnd_w : 17'(div_quot_w);
  assign sum_w = 18'(start_sel_w) + (d_w[16] ? -$signed(18'(r_w)) : $signed(18'(r_w)));

  always_comb begin
    if (sum_w > 18'sd32767) begin
      sample_w = 16'sh7fff;
    end else if (sum_w < -18'sd32768) begin
      sample_w = 16'sh8000;
    end else begin
      sample_w = 16'(sum_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready_w  = 1'b0;
    div_start_w = 1'b0;
    out_load_w  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready_w = 1'b1;
        if (in_chan.valid) begin
          if (in_chan.func == FUNC_START || !moving_r) begin
            state_nxt = S_OUT;
          end else if (cubic_r) begin
            state_nxt = S_TDIV_GO;
          end else begin
            state_nxt = S_J_MUL;
          end
        end
      end
      S_TDIV_GO: begin
        div_start_w = 1'b1;
        state_nxt   = S_TDIV_WAIT;
      end
      S_TDIV_WAIT: begin
        if (!div_busy_w) begin
          state_nxt = S_T2_MUL;
        end
      end
      S_T2_MUL: state_nxt = S_T2_RND;
      S_T2_RND: state_nxt = S_T3_MUL;
      S_T3_MUL: state_nxt = S_S_CALC;
      S_S_CALC: state_nxt = S_J_MUL;
      S_J_MUL: begin
        state_nxt = cubic_r ? S_J_FIN : S_J_DIV_GO;
      end
      S_J_DIV_GO: begin
        div_start_w = 1'b1;
        state_nxt   = S_J_DIV_WAIT;
      end
      S_J_DIV_WAIT: begin
        if (!div_busy_w) begin
          state_nxt = (j_r == LAST_J) ? S_OUT : S_J_MUL;
        end
      end
      S_J_FIN: begin
        state_nxt = (j_r == LAST_J) ? S_OUT : S_J_MUL;
      end
      S_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load_w = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < JOINTS; j++) begin
        start_r[j] <= (j == 1) ? HOME_SHOULDER : (j == 2) ? HOME_ELBOW : angle_t'(0);
        goal_r[j]  <= '0;
      end
      step_index_r <= '0;
      step_total_r <= '0;
      cubic_r      <= 1'b0;
      moving_r     <= 1'b0;
    end else begin
      if (accept_w && in_chan.func == FUNC_START && !moving_r &&
          (in_chan.mode == MODE_LINEAR || in_chan.mode == MODE_CUBIC) && dur_w != '0) begin
        for (int j = 0; j < JOINTS; j++) begin
          goal_r[j] <= (j == 0) ? in_chan.target_rotation :
                       (j == 1) ? in_chan.target_shoulder :
                       (j == 2) ? in_chan.target_elbow : angle_t'(0);
        end
        step_total_r <= dur_w;
        step_index_r <= '0;
        cubic_r      <= in_chan.mode == MODE_CUBIC;
        moving_r     <= 1'b1;
      end
      if (out_load_w && res_sample_r) begin
        step_index_r <= k_r;
        if (res_last_r) begin
          for (int j = 0; j < JOINTS; j++) begin
            start_r[j] <= goal_r[j];
          end
          moving_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_w) begin
      j_r        <= '0;
      k_r        <= k_w;
      if (in_chan.func == FUNC_START) begin
        res_sample_r <= 1'b0;
        res_last_r   <= 1'b0;
        if (moving_r) begin
          res_status_r <= STATUS_BUSY;
        end else if (in_chan.mode != MODE_LINEAR && in_chan.mode != MODE_CUBIC) begin
          res_status_r <= STATUS_BAD_MODE;
        end else if (dur_w == '0) begin
          res_status_r <= STATUS_ZERO_DUR;
        end else begin
          res_status_r <= STATUS_OK;
        end
      end else begin
        res_status_r <= STATUS_OK;
        res_sample_r <= moving_r;
        res_last_r   <= moving_r && (k_w >= step_total_r);
      end
    end
    if (state_r == S_TDIV_WAIT && !div_busy_w) begin
      t_r <= 17'(div_quot_w);
    end
    if (state_r == S_T2_MUL || state_r == S_T3_MUL || state_r == S_J_MUL) begin
      p_r <= mul_a_w * mul_b_w;
    end
    if (state_r == S_T2_RND) begin
      t2_r <= rnd_w;
    end
    if (state_r == S_S_CALC) begin
      s_r <= s_clamp_w;
    end
    if (fin_w) begin
      res_r[j_r] <= sample_w;
      j_r        <= j_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_w) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    rot_sel_w = '0;
    sho_sel_w = '0;
    elb_sel_w = '0;
    if (res_sample_r) begin
      for (int j = 0; j < JOINTS; j++) begin
        if (j == 0) begin
          rot_sel_w = res_r[j];
        end
        if (j == 1) begin
          sho_sel_w = res_r[j];
        end
        if (j == 2) begin
          elb_sel_w = res_r[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_w) begin
      out_status_r <= res_status_r;
      out_sample_r <= res_sample_r;
      out_last_r   <= res_last_r;
      out_rot_r    <= rot_sel_w;
      out_sho_r    <= sho_sel_w;
      out_elb_r    <= elb_sel_w;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.sample_valid   = out_sample_r;
  assign out_chan.angle_rotation = out_rot_r;
  assign out_chan.angle_shoulder = out_sho_r;
  assign out_chan.angle_elbow    = out_elb_r;
  assign out_chan.last_sample    = out_last_r;

endmodule

>>> sim/tb_joint_trajectory_interpolator_top.sv
// ----------------------------------------------------------------------------
// tb_joint_trajectory_interpolator_top
// Drives move and tick transactions into the interpolator and checks every
// sample against a local linear/cubic interpolation model. The sender runs in
// bursts with random gaps and the receiver stalls on its own pattern. Directed
// tests cover idle ticks, start errors, busy starts, extreme moves and one
// long cubic move; random starts, ticks and noise follow while it still runs.
// ----------------------------------------------------------------------------
module tb_joint_trajectory_interpolator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jti_pkg::*;

  localparam int JOINTS         = 3;
  localparam int STEP_BITS      = 12;
  localparam int RESET_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 150;
  localparam int RANDOM_ITEMS   = 730;

  localparam angle_t ANG_MAX = 16'sh7fff;
  localparam angle_t ANG_MIN = 16'sh8000;
  localparam logic   FUNC_TICK = ~FUNC_START;
  localparam mode_t  MODE_BAD_LO = 2'd0;
  localparam mode_t  MODE_BAD_HI = 2'd3;

  typedef struct packed {
    logic   func;
    mode_t  mode;
    dur_t   dur;
    angle_t rot;
    angle_t sho;
    angle_t elb;
  } move_req_t;

  typedef struct packed {
    status_t status;
    logic    sample_valid;
    angle_t  rot;
    angle_t  sho;
    angle_t  elb;
    logic    last;
  } joint_sample_t;

  logic clk = 1'b0;
  logic rst_n;

  jti_in_if  in_chan ();
  jti_out_if out_chan ();

  joint_trajectory_interpolator_top #(
    .JOINTS    (JOINTS),
    .STEP_BITS (STEP_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #6 clk = ~clk;

  // interpolator model state
  angle_t      start_pose [JOINTS];
  angle_t      goal_pose  [JOINTS];
  int unsigned step_idx;
  int unsigned step_tot;
  bit          cubic_move;
  bit          traj_moving;

  joint_sample_t expected_samples [$];
  int unsigned   mismatch_cnt = 0;
  int unsigned   items_sent   = 0;
  int unsigned   burst_left   = 0;
  int unsigned   idle_cycles  = 0;
  int unsigned   stall_left   = 0;
  int unsigned   stall_mode   = 0;
  joint_sample_t got_s;
  joint_sample_t want_s;

  function automatic void pose_reset();
    foreach (start_pose[j]) begin
      start_pose[j] = '0;
      goal_pose[j]  = '0;
    end
    start_pose[1] = HOME_SHOULDER;
    start_pose[2] = HOME_ELBOW;
    step_idx    = 0;
    step_tot    = 0;
    cubic_move  = 1'b0;
    traj_moving = 1'b0;
  endfunction

  function automatic angle_t joint_sample(angle_t y0, angle_t y1, longint k, longint n,
                                          bit cubic);
    longint d, mag, r, t, t2, t3, s, y;
    d   = longint'(y1) - longint'(y0);
    mag = (d < 0) ? -d : d;
    if (!cubic) begin
      r = (mag * k + n / 2) / n;
    end else begin
      t = (k * 65536 + n / 2) / n;
      if (t > 65536) t = 65536;
      t2 = (t * t + 32768) >>> 16;
      t3 = (t2 * t + 32768) >>> 16;
      s  = 3 * t2 - 2 * t3;
      if (s < 0) s = 0;
      if (s > 65536) s = 65536;
      r = (mag * s + 32768) >>> 16;
    end
    y = (d < 0) ? longint'(y0) - r : longint'(y0) + r;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return angle_t'(y);
  endfunction

  function automatic void predict_request(move_req_t rq);
    joint_sample_t es;
    int unsigned   k;
    angle_t        y [JOINTS];
    es = '0;
    if (rq.func == FUNC_START) begin
      if (traj_moving) begin
        es.status = STATUS_BUSY;
      end else if (rq.mode != MODE_LINEAR && rq.mode != MODE_CUBIC) begin
        es.status = STATUS_BAD_MODE;
      end else if (rq.dur == '0) begin
        es.status = STATUS_ZERO_DUR;
      end else begin
        goal_pose[0] = rq.rot;
        goal_pose[1] = rq.sho;
        goal_pose[2] = rq.elb;
        step_tot    = rq.dur;
        step_idx    = 0;
        cubic_move  = (rq.mode == MODE_CUBIC);
        traj_moving = 1'b1;
      end
    end else if (traj_moving) begin
      k = (step_idx + 1) % (1 << STEP_BITS);
      foreach (y[j]) y[j] = joint_sample(start_pose[j], goal_pose[j], k, step_tot, cubic_move);
      es.status       = STATUS_OK;
      es.sample_valid = 1'b1;
      es.rot          = y[0];
      es.sho          = y[1];
      es.elb          = y[2];
      es.last         = (k >= step_tot);
      step_idx = k;
      if (es.last) begin
        foreach (start_pose[j]) start_pose[j] = goal_pose[j];
        traj_moving = 1'b0;
      end
    end
    expected_samples = {expected_samples, es};
  endfunction

  function automatic move_req_t make_req(logic f, mode_t m, dur_t d, angle_t r, angle_t s,
                                         angle_t e);
    move_req_t rq;
    rq.func = f;
    rq.mode = m;
    rq.dur  = d;
    rq.rot  = r;
    rq.sho  = s;
    rq.elb  = e;
    return rq;
  endfunction

  function automatic angle_t rand_angle();
    case ($urandom_range(0, 7))
      0:       return ANG_MAX;
      1:       return ANG_MIN;
      2:       return '0;
      default: return angle_t'($urandom);
    endcase
  endfunction

  function automatic move_req_t rand_req(logic f);
    return make_req(f, mode_t'($urandom_range(0, 3)), dur_t'($urandom), rand_angle(),
                    rand_angle(), rand_angle());
  endfunction

  task automatic push_request(move_req_t rq);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 120);
      else gap = $urandom_range(1, 6);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_chan.valid           <= 1'b1;
    in_chan.func            <= rq.func;
    in_chan.mode            <= rq.mode;
    in_chan.duration_ticks  <= rq.dur;
    in_chan.target_rotation <= rq.rot;
    in_chan.target_shoulder <= rq.sho;
    in_chan.target_elbow    <= rq.elb;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_request(rq);
    items_sent++;
    burst_left--;
  endtask

  task automatic hold_until_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  task automatic push_ticks(int unsigned n);
    repeat (n) push_request(rand_req(FUNC_TICK));
  endtask

  task automatic test_idle_ticks();
    push_request(make_req(FUNC_TICK, MODE_BAD_LO, '0, '0, '0, '0));
    push_request(make_req(FUNC_TICK, MODE_BAD_HI, '1, '1, '1, '1));
  endtask

  task automatic test_start_errors();
    push_request(make_req(FUNC_START, MODE_BAD_LO, '1, ANG_MAX, ANG_MIN, ANG_MAX));
    push_request(make_req(FUNC_START, MODE_BAD_HI, '0, ANG_MIN, ANG_MAX, '0));
    push_request(make_req(FUNC_START, MODE_LINEAR, '0, '1, '0, '1));
    push_request(make_req(FUNC_START, MODE_CUBIC, '0, ANG_MIN, ANG_MIN, ANG_MIN));
  endtask

  task automatic test_linear_move();
    push_request(make_req(FUNC_START, MODE_LINEAR, 12'd3, ANG_MAX, ANG_MIN, '0));
    push_request(make_req(FUNC_START, MODE_BAD_LO, '0, '0, '0, '0));
    push_ticks(3);
    push_request(make_req(FUNC_TICK, MODE_LINEAR, 12'd1, '0, '0, '0));
    push_request(make_req(FUNC_START, MODE_LINEAR, 12'd1, ANG_MIN, ANG_MAX, '0));
    push_ticks(1);
  endtask

  task automatic test_cubic_move();
    push_request(make_req(FUNC_START, MODE_CUBIC, 12'd5, 16'sd1234, -16'sd20000, 16'sd4096));
    push_ticks(2);
    push_request(make_req(FUNC_START, MODE_CUBIC, 12'd1200, ANG_MAX, ANG_MAX, ANG_MAX));
    push_ticks(3);
    hold_until_drained();
  endtask

  task automatic test_long_move();
    push_request(make_req(FUNC_START, MODE_CUBIC, '1, ANG_MIN, ANG_MAX, ANG_MIN));
    push_ticks(1200);
  endtask

  task automatic run_random_move();
    int unsigned n, sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) n = $urandom_range(1, 6);
    else if (sel < 98) n = $urandom_range(7, 40);
    else n = $urandom_range(41, 200);
    push_request(make_req(FUNC_START, $urandom_range(0, 1) ? MODE_CUBIC : MODE_LINEAR,
                          dur_t'(n), rand_angle(), rand_angle(), rand_angle()));
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) push_request(rand_req(FUNC_START));
      if ($urandom_range(0, 99) == 0) hold_until_drained();
      push_request(rand_req(FUNC_TICK));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at, pick;
    move_req_t   rq;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        run_random_move();
      end else if (pick < 87) begin
        rq = rand_req(FUNC_START);
        if ($urandom_range(0, 1)) rq.mode = $urandom_range(0, 1) ? MODE_BAD_HI : MODE_BAD_LO;
        else rq.dur = '0;
        push_request(rq);
      end else if (pick < 98) begin
        push_request(rand_req(FUNC_TICK));
      end else begin
        hold_until_drained();
      end
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(32, 400);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_chan.ready <= 1'b1;
      1:       out_chan.ready <= 1'($urandom_range(0, 1));
      default: out_chan.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got_s.status       = out_chan.status;
      got_s.sample_valid = out_chan.sample_valid;
      got_s.rot          = out_chan.angle_rotation;
      got_s.sho          = out_chan.angle_shoulder;
      got_s.elb          = out_chan.angle_elbow;
      got_s.last         = out_chan.last_sample;
      if (expected_samples.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected sample st=%0d v=%0b rot=%0d sho=%0d elb=%0d last=%0b",
                   $realtime, got_s.status, got_s.sample_valid, got_s.rot, got_s.sho,
                   got_s.elb, got_s.last);
      end else begin
        want_s = expected_samples.pop_front();
        if (got_s !== want_s) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"%0t: sample mismatch exp st=%0d v=%0b rot=%0d sho=%0d elb=%0d ",
                      "last=%0b got st=%0d v=%0b rot=%0d sho=%0d elb=%0d last=%0b"},
                     $realtime, want_s.status, want_s.sample_valid, want_s.rot, want_s.sho,
                     want_s.elb, want_s.last, got_s.status, got_s.sample_valid, got_s.rot,
                     got_s.sho, got_s.elb, got_s.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n                   = 1'b0;
    in_chan.valid           = 1'b0;
    in_chan.func            = FUNC_START;
    in_chan.mode            = MODE_BAD_LO;
    in_chan.duration_ticks  = '0;
    in_chan.target_rotation = '0;
    in_chan.target_shoulder = '0;
    in_chan.target_elbow    = '0;
    out_chan.ready          = 1'b0;
    pose_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_ticks();
    test_start_errors();
    test_linear_move();
    test_cubic_move();
    test_long_move();
    test_random_traffic();
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/jti_pkg.sv
hdl/jti_if.sv
hdl/jti_div.sv
hdl/joint_trajectory_interpolator_top.sv
sim/tb_joint_trajectory_interpolator_top.sv
